// File: design/bsem_pkg.sv
// Shared types and codes for the binary semaphore bank with priority wait queues.
package bsem_pkg;

   localparam int unsigned KIND_BITS = 3;
   localparam int unsigned STAT_BITS = 3;
   localparam int unsigned PRIO_BITS = 3;
   localparam int unsigned SIDX_BITS = 5;
   localparam int unsigned WID_BITS  = 8;
   localparam int unsigned CNT_BITS  = 7;

   localparam logic [KIND_BITS-1:0] KIND_INIT    = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_WAIT    = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_SIGNAL  = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_DESTROY = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_READ    = 3'd4;

   localparam logic [STAT_BITS-1:0] STAT_OK        = 3'd0;
   localparam logic [STAT_BITS-1:0] STAT_NOT_INIT  = 3'd1;
   localparam logic [STAT_BITS-1:0] STAT_ALREADY   = 3'd2;
   localparam logic [STAT_BITS-1:0] STAT_WAITERS   = 3'd3;
   localparam logic [STAT_BITS-1:0] STAT_BAD_ARG   = 3'd4;
   localparam logic [STAT_BITS-1:0] STAT_QUEUE_FULL = 3'd5;

   // operation classified by the front end
   typedef enum logic [2:0] {
      OP_REJECT,
      OP_INIT,
      OP_WAIT,
      OP_SIGNAL,
      OP_DESTROY,
      OP_READ
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [SIDX_BITS-1:0]   sem;
      logic                   init_value;
      logic [PRIO_BITS-1:0]   prio;   // zero-based priority
      logic [WID_BITS-1:0]    wid;
   } cmd_type;

endpackage

// File: design/bsem_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bsem_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: design/bsem_front.sv
// Front end: accepts requests, checks arguments and queues classified commands.
module bsem_front #(
   parameter int unsigned NUM_SEMS  = 32,
   parameter int unsigned NUM_PRIOS = 5,
   parameter int unsigned ID_BITS   = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bsem_pkg::KIND_BITS-1:0]      req_type,
   input  logic [bsem_pkg::SIDX_BITS-1:0]      req_sem_index,
   input  logic                                req_init_value,
   input  logic [bsem_pkg::PRIO_BITS-1:0]      req_priority_req,
   input  logic [bsem_pkg::WID_BITS-1:0]       req_waiter_id,
   output logic                                cmd_valid,
   input  logic                                cmd_ready,
   output bsem_pkg::cmd_type                   cmd
);
   localparam logic [bsem_pkg::WID_BITS-1:0] ID_MASK =
      (ID_BITS >= bsem_pkg::WID_BITS) ? {bsem_pkg::WID_BITS{1'b1}} :
      bsem_pkg::WID_BITS'((9'd1 << ID_BITS) - 9'd1);

   // two-entry queue between front and back
   bsem_pkg::cmd_type q_ff [2];
   bsem_pkg::cmd_type q_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              rd_ff, rd_in;
   logic              push, pop;

   always_comb begin
      q_in            = '0;
      q_in.sem        = req_sem_index;
      q_in.init_value = req_init_value;
      q_in.prio       = req_priority_req - 3'd1;
      q_in.wid        = req_waiter_id & ID_MASK;
      if (32'(req_sem_index) >= NUM_SEMS) begin
         q_in.op = bsem_pkg::OP_REJECT;
      end else begin
         unique case (req_type)
            bsem_pkg::KIND_INIT:    q_in.op = bsem_pkg::OP_INIT;
            bsem_pkg::KIND_WAIT: begin
               if (req_priority_req == 3'd0 || 32'(req_priority_req) > NUM_PRIOS) begin
                  q_in.op = bsem_pkg::OP_REJECT;
               end else begin
                  q_in.op = bsem_pkg::OP_WAIT;
               end
            end
            bsem_pkg::KIND_SIGNAL:  q_in.op = bsem_pkg::OP_SIGNAL;
            bsem_pkg::KIND_DESTROY: q_in.op = bsem_pkg::OP_DESTROY;
            bsem_pkg::KIND_READ:    q_in.op = bsem_pkg::OP_READ;
            default:                q_in.op = bsem_pkg::OP_REJECT;
         endcase
      end
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;
   assign rd_in     = pop ? ~rd_ff : rd_ff;
   assign cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
      if (push) begin
         q_ff[rd_ff ^ cnt_ff[0]] <= q_in;
      end
   end
endmodule

// File: design/bsem_back.sv
// Back end: per-semaphore state, queue pointers and the waiter id memory.
module bsem_back #(
   parameter int unsigned NUM_SEMS    = 32,
   parameter int unsigned NUM_PRIOS   = 5,
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_valid,
   output logic                            cmd_ready,
   input  bsem_pkg::cmd_type               cmd,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [bsem_pkg::STAT_BITS-1:0]  rsp_status,
   output logic                            rsp_blocked,
   output logic                            rsp_woke_valid,
   output logic [bsem_pkg::WID_BITS-1:0]   rsp_woke_id,
   output logic signed [1:0]               rsp_sem_value,
   output logic [bsem_pkg::CNT_BITS-1:0]   rsp_wait_count
);
   localparam int unsigned SB      = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int unsigned PRB     = (NUM_PRIOS > 1) ? $clog2(NUM_PRIOS) : 1;
   localparam int unsigned PB      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned FB      = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned MD      = NUM_SEMS * NUM_PRIOS * QUEUE_DEPTH;
   localparam int unsigned MB      = (MD > 1) ? $clog2(MD) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_POP, ST_OUT} state_type;

   state_type state_ff;
   logic [NUM_SEMS-1:0]           valid_ff, bit_ff;
   logic [bsem_pkg::CNT_BITS-1:0] total_ff [NUM_SEMS];
   // one row per semaphore holds the pointers of all its priority queues
   logic [NUM_PRIOS-1:0][PB-1:0]  head_ff [NUM_SEMS];
   logic [NUM_PRIOS-1:0][PB-1:0]  tail_ff [NUM_SEMS];
   logic [NUM_PRIOS-1:0][FB-1:0]  fill_ff [NUM_SEMS];

   bsem_pkg::cmd_type             c_ff;
   logic [PRB-1:0]                p_ff;     // priority chosen for pop
   logic [bsem_pkg::STAT_BITS-1:0] status_ff;
   logic                          blocked_ff, woke_valid_ff;
   logic [bsem_pkg::WID_BITS-1:0] woke_id_ff;
   logic signed [1:0]             sval_ff;
   logic [bsem_pkg::CNT_BITS-1:0] wcnt_ff;

   logic                          mem_we;
   logic [MB-1:0]                 mem_wa, mem_ra;
   logic [bsem_pkg::WID_BITS-1:0] mem_rd;

   logic [SB-1:0]                 s;
   logic [PRB-1:0]                wp;
   logic [NUM_PRIOS-1:0][PB-1:0]  head_row, tail_row;
   logic [NUM_PRIOS-1:0][FB-1:0]  fill_row;
   logic                          found;
   logic [PRB-1:0]                found_p;

   assign s        = SB'(c_ff.sem);
   assign wp       = PRB'(c_ff.prio);
   assign head_row = head_ff[s];
   assign tail_row = tail_ff[s];
   assign fill_row = fill_ff[s];

   // highest-priority nonempty queue
   always_comb begin
      found   = 1'b0;
      found_p = '0;
      for (int p = NUM_PRIOS - 1; p >= 0; p--) begin
         if (fill_row[p] != '0) begin
            found   = 1'b1;
            found_p = PRB'(p);
         end
      end
   end

   assign mem_we = (state_ff == ST_EXEC) && c_ff.op == bsem_pkg::OP_WAIT &&
                   valid_ff[s] && !bit_ff[s] && 32'(fill_row[wp]) < QUEUE_DEPTH;
   assign mem_wa = MB'((32'(s) * NUM_PRIOS + 32'(wp)) * QUEUE_DEPTH + 32'(tail_row[wp]));
   assign mem_ra = MB'((32'(s) * NUM_PRIOS + 32'(found_p)) * QUEUE_DEPTH +
                       32'(head_row[found_p]));

   bsem_ram #(.WIDTH(bsem_pkg::WID_BITS), .DEPTH(MD)) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (c_ff.wid),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   function automatic logic [PB-1:0] next_slot(input logic [PB-1:0] p);
      next_slot = (32'(p) + 1 >= QUEUE_DEPTH) ? '0 : PB'(p + 1'b1);
   endfunction

   assign cmd_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = (state_ff == ST_OUT);
   assign rsp_status     = status_ff;
   assign rsp_blocked    = blocked_ff;
   assign rsp_woke_valid = woke_valid_ff;
   assign rsp_woke_id    = woke_id_ff;
   assign rsp_sem_value  = sval_ff;
   assign rsp_wait_count = wcnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         bit_ff   <= '0;
         for (int i = 0; i < NUM_SEMS; i++) begin
            total_ff[i] <= '0;
            head_ff[i]  <= '0;
            tail_ff[i]  <= '0;
            fill_ff[i]  <= '0;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  c_ff     <= cmd;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               status_ff     <= bsem_pkg::STAT_OK;
               blocked_ff    <= 1'b0;
               woke_valid_ff <= 1'b0;
               woke_id_ff    <= '0;
               sval_ff       <= 2'sd0;
               wcnt_ff       <= '0;
               state_ff      <= ST_OUT;
               unique case (c_ff.op)
                  bsem_pkg::OP_REJECT: status_ff <= bsem_pkg::STAT_BAD_ARG;
                  bsem_pkg::OP_INIT: begin
                     if (valid_ff[s]) begin
                        status_ff <= bsem_pkg::STAT_ALREADY;
                     end else begin
                        valid_ff[s] <= 1'b1;
                        bit_ff[s]   <= c_ff.init_value;
                        total_ff[s] <= '0;
                        head_ff[s]  <= '0;
                        tail_ff[s]  <= '0;
                        fill_ff[s]  <= '0;
                     end
                  end
                  bsem_pkg::OP_WAIT: begin
                     if (!valid_ff[s]) begin
                        status_ff <= bsem_pkg::STAT_NOT_INIT;
                     end else if (bit_ff[s]) begin
                        bit_ff[s] <= 1'b0;
                     end else if (32'(fill_row[wp]) >= QUEUE_DEPTH) begin
                        status_ff <= bsem_pkg::STAT_QUEUE_FULL;
                     end else begin
                        tail_ff[s][wp] <= next_slot(tail_row[wp]);
                        fill_ff[s][wp] <= fill_row[wp] + 1'b1;
                        total_ff[s]    <= total_ff[s] + 1'b1;
                        blocked_ff     <= 1'b1;
                     end
                  end
                  bsem_pkg::OP_SIGNAL: begin
                     if (!valid_ff[s]) begin
                        status_ff <= bsem_pkg::STAT_NOT_INIT;
                     end else if (!bit_ff[s]) begin
                        if (found) begin
                           // memory read of the head issued this cycle
                           p_ff     <= found_p;
                           state_ff <= ST_POP;
                        end else begin
                           bit_ff[s]   <= 1'b1;
                           total_ff[s] <= '0;
                        end
                     end
                  end
                  bsem_pkg::OP_DESTROY: begin
                     if (!valid_ff[s]) begin
                        status_ff <= bsem_pkg::STAT_NOT_INIT;
                     end else if (total_ff[s] != '0) begin
                        status_ff <= bsem_pkg::STAT_WAITERS;
                     end else begin
                        valid_ff[s] <= 1'b0;
                        bit_ff[s]   <= 1'b0;
                     end
                  end
                  bsem_pkg::OP_READ: begin
                     if (valid_ff[s]) begin
                        sval_ff <= $signed({1'b0, bit_ff[s]});
                        wcnt_ff <= total_ff[s];
                     end else begin
                        sval_ff <= -2'sd1;
                     end
                  end
                  default: status_ff <= bsem_pkg::STAT_BAD_ARG;
               endcase
            end
            ST_POP: begin
               woke_valid_ff    <= 1'b1;
               woke_id_ff       <= mem_rd;
               head_ff[s][p_ff] <= next_slot(head_row[p_ff]);
               fill_ff[s][p_ff] <= fill_row[p_ff] - 1'b1;
               if (total_ff[s] != '0) total_ff[s] <= total_ff[s] - 1'b1;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (rsp_ready) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// File: design/binary_semaphore_priority_waitq_unit.sv
// Top level of the binary semaphore bank with priority wait queues.
// Usage:
//  - Request channel (req_*): valid/ready; one transaction carries a request
//    kind, target semaphore, init value, wait priority (1 highest) and waiter id.
//  - Response channel (rsp_*): valid/ready; exactly one transaction per request,
//    in request order.
//  - The front end checks arguments and pushes a classified command into a
//    two-entry queue; the back end executes it against the semaphore table.
//  - The back end sequencer steps each request through the idle, execute and
//    output states, with a pop state between execute and output for a signal
//    that wakes a waiter (for the registered read of the waiter id memory).
//    It takes no new command until the response handshake completes, so a
//    stalled receiver holds the back end in the output state.
//  - Reset clears all semaphores, counts and queue pointers at once; the id
//    memory needs no clearing since only written entries are ever read.
//  - When the receiver stalls, the response holds and the front queue keeps
//    taking up to two more requests before req_ready drops.
module binary_semaphore_priority_waitq_unit #(
   parameter int unsigned NUM_SEMS    = 32,
   parameter int unsigned NUM_PRIOS   = 5,
   parameter int unsigned QUEUE_DEPTH = 16,
   parameter int unsigned ID_BITS     = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [bsem_pkg::KIND_BITS-1:0] req_type,
   input  logic [bsem_pkg::SIDX_BITS-1:0] req_sem_index,
   input  logic                           req_init_value,
   input  logic [bsem_pkg::PRIO_BITS-1:0] req_priority_req,
   input  logic [bsem_pkg::WID_BITS-1:0]  req_waiter_id,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [bsem_pkg::STAT_BITS-1:0] rsp_status,
   output logic                           rsp_blocked,
   output logic                           rsp_woke_valid,
   output logic [bsem_pkg::WID_BITS-1:0]  rsp_woke_id,
   output logic signed [1:0]              rsp_sem_value,
   output logic [bsem_pkg::CNT_BITS-1:0]  rsp_wait_count
);
   logic              cmd_valid, cmd_ready;
   bsem_pkg::cmd_type cmd;

   bsem_front #(.NUM_SEMS(NUM_SEMS), .NUM_PRIOS(NUM_PRIOS), .ID_BITS(ID_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_sem_index    (req_sem_index),
      .req_init_value   (req_init_value),
      .req_priority_req (req_priority_req),
      .req_waiter_id    (req_waiter_id),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd              (cmd)
   );

   bsem_back #(.NUM_SEMS(NUM_SEMS), .NUM_PRIOS(NUM_PRIOS),
               .QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_blocked    (rsp_blocked),
      .rsp_woke_valid (rsp_woke_valid),
      .rsp_woke_id    (rsp_woke_id),
      .rsp_sem_value  (rsp_sem_value),
      .rsp_wait_count (rsp_wait_count)
   );

   // a blocked wait and a wakeup never come in one response
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_blocked && rsp_woke_valid))
      else $error("blocked and woke both set");

   // a wakeup response always reports success
   a_woke_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_woke_valid) |-> rsp_status == bsem_pkg::STAT_OK)
      else $error("wakeup with error status");

   // back end takes no command while a response is pending
   a_nooverlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !cmd_ready)
      else $error("command taken during pending response");
endmodule
